// ===== sv/ovn_pkg.sv =====
// Shared types, constants and fade-table helpers for the octave value noise unit.
// Depends on nothing; every other file refers to it by scoped names.
package ovn_pkg;

  localparam int MAX_OCTAVES_DEF     = 8;
  localparam int FADE_TABLE_BITS_DEF = 10;

  localparam int COORD_W = 32;
  localparam int H_W     = 32;   // lattice value, signed Q1.30
  localparam int S_W     = 36;   // smoothed value, signed Q.34
  localparam int TOTAL_W = 40;   // octave sum, room for sixteen terms
  localparam int AMP_W   = 17;   // amplitude, 0..65536
  localparam int FADE_W  = 17;   // fade weight, 0..65536
  localparam int PERS_W  = 16;
  localparam int COUNT_W = 4;
  localparam int CEFF_W  = 5;    // clamped octave count, 0..15
  localparam int OUT_W   = 18;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 1'd1;

  localparam logic [PERS_W-1:0]  PERSISTENCE_RST  = 16'd32768;
  localparam logic [COUNT_W-1:0] OCTAVE_COUNT_RST = 4'd8;
  localparam logic [AMP_W-1:0]   AMP_ONE          = 17'd65536;

  localparam logic [31:0] HASH_MUL_A = 32'd15731;
  localparam logic [31:0] HASH_ADD_A = 32'd789221;
  localparam logic [31:0] HASH_ADD_B = 32'd1376312589;
  localparam logic [31:0] ONE_Q30    = 32'h4000_0000;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned Q30    = 64'd1073741824;

  // Item state handed from one octave cell to the next.
  typedef struct packed {
    logic [COORD_W-1:0]        x;
    logic [COORD_W-1:0]        y;
    logic signed [TOTAL_W-1:0] total;
    logic [AMP_W-1:0]          amp;
  } ovn_link_t;

  // Per-stage sidecar inside a cell.
  typedef struct packed {
    ovn_link_t         link;
    logic [FADE_W-1:0] f1;
    logic [FADE_W-1:0] f2;
    logic              active;
  } ovn_side_t;

  // Cosine fade for the lower half of the table (Horner series in Q2.30, result rounded to Q.16).
  function automatic longint unsigned fade_half(input longint unsigned k, input int bits);
    longint unsigned theta;
    longint unsigned t;
    longint unsigned r;
    theta = (PI_Q30 * k) >> bits;
    t = (theta * theta) >> 30;
    r = Q30;
    r = Q30 - ((t * r) >> 30) / 64'd182;
    r = Q30 - ((t * r) >> 30) / 64'd132;
    r = Q30 - ((t * r) >> 30) / 64'd90;
    r = Q30 - ((t * r) >> 30) / 64'd56;
    r = Q30 - ((t * r) >> 30) / 64'd30;
    r = Q30 - ((t * r) >> 30) / 64'd12;
    return ((((t * r) >> 30) >> 2) + 64'd8192) >> 14;
  endfunction

  function automatic longint unsigned fade_entry(input int k, input int bits);
    longint unsigned n;
    longint unsigned kk;
    n  = 64'd1 << bits;
    kk = longint'(k);
    if (2 * kk <= n) begin
      return fade_half(kk, bits);
    end
    return 64'd65536 - fade_half(n - kk, bits);
  endfunction

endpackage

// ===== sv/ovn_hash.sv =====
// One lattice hash lane: integer hash of a lattice point, four register stages.
// Depends on ovn_pkg for widths and hash constants.
module ovn_hash (
  input  logic                             clk,
  input  logic                             en,
  input  logic [ovn_pkg::COORD_W-1:0]      x_in,
  input  logic [ovn_pkg::COORD_W-1:0]      y_in,
  output logic signed [ovn_pkg::H_W-1:0]   h_out
);

  logic [31:0] n0;
  logic [31:0] n_r, n2_r, n3_r, m1_r, m2_r;
  logic [31:0] m3;
  logic signed [ovn_pkg::H_W-1:0] h_r;

  // x + 57*y, all wrapping at 32 bits
  assign n0 = x_in + (y_in << 5) + (y_in << 4) + (y_in << 3) + y_in;
  assign m3 = n3_r * m2_r + ovn_pkg::HASH_ADD_B;

  always_ff @(posedge clk) begin
    if (en) begin
      n_r  <= (n0 << 13) ^ n0;
      n2_r <= n_r;
      m1_r <= n_r * n_r;
      n3_r <= n2_r;
      m2_r <= m1_r * ovn_pkg::HASH_MUL_A + ovn_pkg::HASH_ADD_A;
      h_r  <= signed'(ovn_pkg::ONE_Q30 - {1'b0, m3[30:0]});
    end
  end

  assign h_out = h_r;

endmodule

// ===== sv/ovn_cell.sv =====
// One octave cell: hashes a 4x4 lattice patch, smooths, fades and accumulates one octave.
// Depends on ovn_pkg and ovn_hash; nine register stages from link in to link out.
module ovn_cell #(
  parameter int OCT_IDX         = 0,
  parameter int FADE_TABLE_BITS = ovn_pkg::FADE_TABLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [ovn_pkg::PERS_W-1:0]    persistence,
  input  logic [ovn_pkg::CEFF_W-1:0]    count_eff,
  input  logic                          link_valid_in,
  input  ovn_pkg::ovn_link_t            link_in,
  output logic                          link_valid_out,
  output ovn_pkg::ovn_link_t            link_out
);

  localparam int FADE_N = 1 << FADE_TABLE_BITS;
  localparam int SIDE_N = 8;
  localparam logic [ovn_pkg::CEFF_W-1:0] IDX = ovn_pkg::CEFF_W'(OCT_IDX);

  logic [ovn_pkg::FADE_W-1:0] fade_rom [FADE_N];

  for (genvar k = 0; k < FADE_N; k++) begin : g_fade
    assign fade_rom[k] = ovn_pkg::FADE_W'(ovn_pkg::fade_entry(k, FADE_TABLE_BITS));
  end

  logic [63:0] sx, sy;
  logic [31:0] ix, iy;
  logic [FADE_TABLE_BITS-1:0] fidx_x, fidx_y;

  assign sx = {32'd0, link_in.x} << OCT_IDX;
  assign sy = {32'd0, link_in.y} << OCT_IDX;
  assign ix = sx[47:16];
  assign iy = sy[47:16];
  assign fidx_x = sx[15 -: FADE_TABLE_BITS];
  assign fidx_y = sy[15 -: FADE_TABLE_BITS];

  logic signed [ovn_pkg::H_W-1:0] h [4][4];

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      localparam logic [31:0] OFF_X = 32'(c) - 32'd1;
      localparam logic [31:0] OFF_Y = 32'(r) - 32'd1;
      ovn_hash u_hash (
        .clk   (clk),
        .en    (en),
        .x_in  (ix + OFF_X),
        .y_in  (iy + OFF_Y),
        .h_out (h[r][c])
      );
    end
  end

  ovn_pkg::ovn_side_t side_r [SIDE_N];
  logic [SIDE_N-1:0]  valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[SIDE_N-2:0], link_valid_in};
    end
  end

  // Registered fade lookup rides in the first sidecar stage.
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0].link   <= link_in;
      side_r[0].f1     <= fade_rom[fidx_x];
      side_r[0].f2     <= fade_rom[fidx_y];
      side_r[0].active <= IDX < count_eff;
      for (int k = 1; k < SIDE_N; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // 3x3 smoothing around each of the four cell corners
  logic signed [ovn_pkg::S_W-1:0] s_nxt [2][2];
  logic signed [ovn_pkg::S_W-1:0] s_r   [2][2];

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      for (int c = 0; c < 2; c++) begin
        s_nxt[r][c] =
            ovn_pkg::S_W'(h[r][c]) + ovn_pkg::S_W'(h[r][c+2])
          + ovn_pkg::S_W'(h[r+2][c]) + ovn_pkg::S_W'(h[r+2][c+2])
          + (ovn_pkg::S_W'(h[r+1][c]) <<< 1) + (ovn_pkg::S_W'(h[r+1][c+2]) <<< 1)
          + (ovn_pkg::S_W'(h[r][c+1]) <<< 1) + (ovn_pkg::S_W'(h[r+2][c+1]) <<< 1)
          + (ovn_pkg::S_W'(h[r+1][c+1]) <<< 2);
      end
    end
  end

  // Blend a to b with weight f, floor of the Q.16 product.
  function automatic logic signed [ovn_pkg::S_W-1:0] blend(
    input logic signed [ovn_pkg::S_W-1:0] a,
    input logic signed [ovn_pkg::S_W-1:0] b,
    input logic [ovn_pkg::FADE_W-1:0]     f
  );
    logic [ovn_pkg::FADE_W-1:0] wa;
    logic signed [54:0] acc;
    wa  = ovn_pkg::AMP_ONE - f;
    acc = 55'(a * signed'({1'b0, wa})) + 55'(b * signed'({1'b0, f}));
    return acc[51:16];
  endfunction

  logic signed [ovn_pkg::S_W-1:0] i0_r, i1_r, v_r;
  logic signed [ovn_pkg::TOTAL_W-1:0] term_r;
  logic signed [53:0] prod;

  assign prod = v_r * signed'({1'b0, side_r[6].link.amp});

  logic [32:0] amp_prod;
  assign amp_prod = side_r[7].link.amp * persistence;

  ovn_pkg::ovn_link_t link_r;
  logic               lvalid_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s_r    <= s_nxt;
      i0_r   <= blend(s_r[0][0], s_r[0][1], side_r[4].f1);
      i1_r   <= blend(s_r[1][0], s_r[1][1], side_r[4].f1);
      v_r    <= blend(i0_r, i1_r, side_r[5].f2);
      term_r <= ovn_pkg::TOTAL_W'(signed'(prod[53:16]));
      link_r.x     <= side_r[7].link.x;
      link_r.y     <= side_r[7].link.y;
      link_r.total <= side_r[7].active ? side_r[7].link.total + term_r
                                       : side_r[7].link.total;
      link_r.amp   <= amp_prod[32:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvalid_r <= 1'b0;
    end else if (en) begin
      lvalid_r <= valid_r[SIDE_N-1];
    end
  end

  assign link_valid_out = lvalid_r;
  assign link_out       = link_r;

endmodule

// ===== sv/octave_value_noise_2d_unit.sv =====
// Octave value noise unit: fractal 2D value noise over up to MAX_OCTAVES octaves.
// A request passes through the MAX_OCTAVES octave cells and then the output register.
// Throughput: one request per cycle while not stalled; each cell is fully pipelined.
// The whole chain advances together; it keeps moving while the output register waits
// as long as the last cell holds no finished request.
// Reset (synchronous, active low) clears all valid bits and restores persistence 32768,
// octave count 8; no clearing pass is needed.
module octave_value_noise_2d_unit #(
  parameter int MAX_OCTAVES     = ovn_pkg::MAX_OCTAVES_DEF,
  parameter int FADE_TABLE_BITS = ovn_pkg::FADE_TABLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ovn_pkg::COORD_W-1:0]         in_x_coord,
  input  logic [ovn_pkg::COORD_W-1:0]         in_y_coord,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ovn_pkg::OUT_W-1:0]    out_noise_value,
  input  logic                                cfg_we,
  input  logic [ovn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ovn_pkg::PERS_W-1:0]          cfg_wdata
);

  localparam logic [ovn_pkg::CEFF_W-1:0] MAX_CNT = ovn_pkg::CEFF_W'(MAX_OCTAVES);
  localparam logic signed [ovn_pkg::TOTAL_W-1:0] ROUND_HALF =
      signed'(ovn_pkg::TOTAL_W'(64'd524288));
  localparam logic signed [ovn_pkg::TOTAL_W-1:0] SAT_HI =
      signed'(ovn_pkg::TOTAL_W'(64'd131071));
  localparam logic signed [ovn_pkg::TOTAL_W-1:0] SAT_LO = -SAT_HI - 1;

  // Configuration registers
  logic [ovn_pkg::PERS_W-1:0]  persistence_r;
  logic [ovn_pkg::COUNT_W-1:0] octave_count_r;
  logic [ovn_pkg::CEFF_W-1:0]  count_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      persistence_r  <= ovn_pkg::PERSISTENCE_RST;
      octave_count_r <= ovn_pkg::OCTAVE_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ovn_pkg::REG_PERSISTENCE:  persistence_r  <= cfg_wdata;
        ovn_pkg::REG_OCTAVE_COUNT: octave_count_r <= cfg_wdata[ovn_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the octave count to the number of cells built.
  assign count_eff = ({1'b0, octave_count_r} > MAX_CNT) ? MAX_CNT : {1'b0, octave_count_r};

  // Chain of octave cells. Link 0 is the incoming request.
  logic               link_valid [MAX_OCTAVES+1];
  ovn_pkg::ovn_link_t link       [MAX_OCTAVES+1];
  logic               en;
  logic               out_free;
  logic               out_valid_r;

  assign link_valid[0]  = in_valid;
  assign link[0].x      = in_x_coord;
  assign link[0].y      = in_y_coord;
  assign link[0].total  = '0;
  assign link[0].amp    = ovn_pkg::AMP_ONE;

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
    ovn_cell #(
      .OCT_IDX         (i),
      .FADE_TABLE_BITS (FADE_TABLE_BITS)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .en             (en),
      .persistence    (persistence_r),
      .count_eff      (count_eff),
      .link_valid_in  (link_valid[i]),
      .link_in        (link[i]),
      .link_valid_out (link_valid[i+1]),
      .link_out       (link[i+1])
    );
  end

  // Advance the chain when the output register can take a result, or when the
  // last cell holds nothing that would be dropped.
  assign out_free = !out_valid_r || out_ready;
  assign en       = out_free || !link_valid[MAX_OCTAVES];
  assign in_ready = en;

  // Round Q.34 to Q.14 (floor after adding half) and saturate to 18 bits.
  logic signed [ovn_pkg::TOTAL_W-1:0] rounded;
  logic signed [ovn_pkg::OUT_W-1:0]   sat_nxt;

  assign rounded = (link[MAX_OCTAVES].total + ROUND_HALF) >>> 20;

  always_comb begin
    if (rounded > SAT_HI) begin
      sat_nxt = 18'sd131071;
    end else if (rounded < SAT_LO) begin
      sat_nxt = -18'sd131072;
    end else begin
      sat_nxt = rounded[ovn_pkg::OUT_W-1:0];
    end
  end

  logic signed [ovn_pkg::OUT_W-1:0] out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= link_valid[MAX_OCTAVES];
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_value_r <= sat_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_value_r;

  // A finished request stuck behind a stalled result must hold off new requests.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (link_valid[MAX_OCTAVES] && out_valid_r && !out_ready) |-> !in_ready)
    else $error("request accepted while the chain is blocked");

  // Reset leaves no result pending.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A result that was not taken must still be there next cycle.
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_value_r)))
    else $error("pending result lost or changed");

endmodule
